// File: rtl/bpa_pkg.sv
package bpa_pkg;

    localparam int CFG_W = 17;
    localparam int IDX_W = 16;
    localparam int CNT_W = 11;
    localparam int FCNT_W = 17;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STS_OK  = 1'b0;
    localparam logic STS_OOM = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic pass2;
        logic mark;
        logic free_step;
        logic fin_ok;
        logic fin_fail;
        logic fin_free;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic op_free;
        logic cnt_bad;
        logic found;
        logic exhausted;
        logic mark_done;
    } t_sts;

endpackage

// File: rtl/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bpa_datapath.sv
module bpa_datapath #(
    parameter int PAGE_CAPACITY = 65536,
    parameter int MAX_RUN = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_opcode,
    input  logic [bpa_pkg::IDX_W-1:0]   i_page_index,
    input  logic [bpa_pkg::CNT_W-1:0]   i_page_count,
    input  bpa_pkg::t_cmd               i_cmd,
    output bpa_pkg::t_sts               o_sts,
    output logic                        o_status,
    output logic [bpa_pkg::IDX_W-1:0]   o_start_page,
    output logic [bpa_pkg::FCNT_W-1:0]  o_free_count
);

    import bpa_pkg::*;

    localparam int AW = $clog2(PAGE_CAPACITY);
    localparam int CW = $clog2(PAGE_CAPACITY + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [XW-1:0] CAP_X = XW'(PAGE_CAPACITY);
    localparam logic [XW-1:0] LAST_X = XW'(PAGE_CAPACITY - 1);

    logic [CFG_W-1:0]  r_cfg_total;
    logic [XW-1:0]     r_cursor;
    logic [FCNT_W-1:0] r_free;
    logic              r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [XW-1:0]     r_pos;
    logic [XW-1:0]     r_limit;
    logic [XW-1:0]     r_lim2;
    logic [CNT_W-1:0]  r_run;
    logic              r_rd_vld;
    logic [XW-1:0]     r_rd_page;
    logic [XW-1:0]     r_start;
    logic [XW-1:0]     r_end;
    logic              r_status;
    logic [IDX_W-1:0]  r_start_page;
    logic [FCNT_W-1:0] r_free_out;

    logic [XW-1:0]     w_total;
    logic [XW-1:0]     w_in_end;
    logic [XW-1:0]     w_lim_free;
    logic [XW-1:0]     w_lim2;
    logic              w_issue;
    logic              w_q;
    logic              w_found;
    logic              w_cnt_bad;
    logic              w_mark_done;
    logic              w_inc;
    logic [FCNT_W-1:0] w_free_sub;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic              w_wdata;
    logic [0:0]        w_rdata;

    assign w_total    = (XW'(r_cfg_total) > CAP_X) ? CAP_X : XW'(r_cfg_total);
    assign w_in_end   = XW'(i_page_index) + XW'(i_page_count);
    assign w_lim_free = (w_in_end < w_total) ? w_in_end : w_total;
    assign w_lim2     = (r_cursor < w_total) ? r_cursor : w_total;

    assign w_q         = w_rdata[0];
    assign w_issue     = (r_pos < r_limit);
    assign w_found     = r_rd_vld && !w_q && ((r_run + CNT_W'(1)) == r_cnt);
    assign w_cnt_bad   = (r_cnt == '0) || (32'(r_cnt) > 32'(MAX_RUN));
    assign w_mark_done = (r_pos == r_end);
    assign w_inc       = r_rd_vld && w_q && (XW'(r_free) < w_total);
    assign w_free_sub  = (r_free > FCNT_W'(r_cnt)) ? (r_free - FCNT_W'(r_cnt)) : '0;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = 1'b1;
        if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (i_cmd.mark) begin
            w_we = !w_mark_done;
        end else if (i_cmd.free_step) begin
            w_we    = r_rd_vld && w_q;
            w_waddr = r_rd_page[AW-1:0];
            w_wdata = 1'b0;
        end
    end

    bpa_ram #(
        .WIDTH(1),
        .DEPTH(PAGE_CAPACITY)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_total <= '0;
            r_cursor    <= '0;
            r_free      <= '0;
            r_pos       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_total <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_pos <= r_pos + XW'(1);
            end else if (i_cmd.load) begin
                r_op     <= i_opcode;
                r_cnt    <= i_page_count;
                r_run    <= '0;
                r_rd_vld <= 1'b0;
                r_lim2   <= w_lim2;
                if (i_opcode == OP_FREE) begin
                    r_pos   <= XW'(i_page_index);
                    r_limit <= w_lim_free;
                end else begin
                    r_pos   <= r_cursor;
                    r_limit <= w_total;
                end
            end else if (i_cmd.scan || i_cmd.free_step) begin
                r_rd_vld  <= w_issue;
                r_rd_page <= r_pos;
                if (i_cmd.scan && w_found) begin
                    r_start <= r_rd_page + XW'(1) - XW'(r_cnt);
                    r_end   <= r_rd_page + XW'(1);
                    r_pos   <= r_rd_page + XW'(1) - XW'(r_cnt);
                end else if (w_issue) begin
                    r_pos <= r_pos + XW'(1);
                end
                if (i_cmd.scan && r_rd_vld) begin
                    r_run <= w_q ? '0 : (r_run + CNT_W'(1));
                end
                if (i_cmd.free_step && w_inc) begin
                    r_free <= r_free + FCNT_W'(1);
                end
            end else if (i_cmd.pass2) begin
                r_pos    <= '0;
                r_limit  <= r_lim2;
                r_run    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.mark) begin
                if (!w_mark_done) begin
                    r_pos <= r_pos + XW'(1);
                end
            end else if (i_cmd.fin_ok) begin
                r_cursor     <= r_end;
                r_free       <= w_free_sub;
                r_status     <= STS_OK;
                r_start_page <= r_start[IDX_W-1:0];
                r_free_out   <= w_free_sub;
            end else if (i_cmd.fin_fail) begin
                if (!w_cnt_bad) begin
                    r_cursor <= r_lim2;
                end
                r_status     <= STS_OOM;
                r_start_page <= '0;
                r_free_out   <= r_free;
            end else if (i_cmd.fin_free) begin
                r_status     <= STS_OK;
                r_start_page <= '0;
                r_free_out   <= r_free;
            end
        end
    end

    assign o_sts.clr_last  = (r_pos == LAST_X);
    assign o_sts.op_free   = (r_op == OP_FREE);
    assign o_sts.cnt_bad   = w_cnt_bad;
    assign o_sts.found     = w_found;
    assign o_sts.exhausted = !r_rd_vld && !w_issue;
    assign o_sts.mark_done = w_mark_done;

    assign o_status     = r_status;
    assign o_start_page = r_start_page;
    assign o_free_count = r_free_out;

endmodule

// File: rtl/bpa_ctrl.sv
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);

    import bpa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN1,
        S_SCAN2,
        S_MARK,
        S_FREE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_slot_free;
    logic   w_fin;

    assign w_slot_free = !r_out_vld || !i_out_stall;
    assign w_fin       = o_cmd.fin_ok || o_cmd.fin_fail || o_cmd.fin_free;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_sts.op_free) begin
                    n_state = S_FREE;
                end else if (i_sts.cnt_bad) begin
                    if (w_slot_free) begin
                        o_cmd.fin_fail = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.found) begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_MARK;
                end else if (i_sts.exhausted) begin
                    o_cmd.pass2 = 1'b1;
                    n_state     = S_SCAN2;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SCAN2: begin
                if (i_sts.found) begin
                    o_cmd.scan = 1'b1;
                    n_state    = S_MARK;
                end else if (i_sts.exhausted) begin
                    if (w_slot_free) begin
                        o_cmd.fin_fail = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_MARK: begin
                if (!i_sts.mark_done) begin
                    o_cmd.mark = 1'b1;
                end else if (w_slot_free) begin
                    o_cmd.fin_ok = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FREE: begin
                if (!i_sts.exhausted) begin
                    o_cmd.free_step = 1'b1;
                end else if (w_slot_free) begin
                    o_cmd.fin_free = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_fin) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

`ifndef SYNTH
    a_fin_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && r_out_vld) |-> !i_out_stall)
        else $error("result loaded over a stalled beat");

    a_fin_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.fin_ok, o_cmd.fin_fail, o_cmd.fin_free}))
        else $error("more than one finish command");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("map clear restarted without reset");

    a_mark_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_MARK) ##1 (r_state == S_MARK)) |-> $past(i_sts.found))
        else $error("marking started without a found run");

    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_fin))
        else $error("output valid rose without a finish");
`endif

endmodule

// File: rtl/bitmap_page_allocator_core.sv
// A free clears the used pages among the N pages that lie inside the total; an allocate scans
// for a run of N free pages from the cursor, with a second pass from page 0 when none is found,
// then marks the run; a failed search or a bad page count gives an out-of-memory status.
// Scanning and marking run one page per cycle; one request is in flight, and the next is
// accepted once the result is in the output register.
// Reset marks all pages used; meanwhile input stalls, configuration writes are taken.
module bitmap_page_allocator_core #(
    parameter int PAGE_CAPACITY = 65536,
    parameter int MAX_RUN = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_opcode,
    input  logic [bpa_pkg::IDX_W-1:0]   i_page_index,
    input  logic [bpa_pkg::CNT_W-1:0]   i_page_count,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_status,
    output logic [bpa_pkg::IDX_W-1:0]   o_start_page,
    output logic [bpa_pkg::FCNT_W-1:0]  o_free_count
);

    import bpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bpa_datapath #(
        .PAGE_CAPACITY(PAGE_CAPACITY),
        .MAX_RUN      (MAX_RUN)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_page_index (i_page_index),
        .i_page_count (i_page_count),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_status     (o_status),
        .o_start_page (o_start_page),
        .o_free_count (o_free_count)
    );

endmodule
